// ===== sv/include_directive_line_scanner_core_macros.svh =====
// Assertion macros used by the bound checker in idls_checker.sv.
`ifndef INCLUDE_DIRECTIVE_LINE_SCANNER_CORE_MACROS_SVH
`define INCLUDE_DIRECTIVE_LINE_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/idls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package idls_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int POS_BITS    = OFFSET_BITS + 1;
  localparam int FIELD_BITS  = 16;
  localparam int KW_LEN      = 8;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;

  typedef enum logic [5:0] {
    PH_LEAD    = 6'b000001,
    PH_KEYWORD = 6'b000010,
    PH_GAP     = 6'b000100,
    PH_PATH    = 6'b001000,
    PH_FOUND   = 6'b010000,
    PH_FAIL    = 6'b100000
  } phase_e;

  // Bytes of the directive keyword, index 0 is the hash.
  function automatic logic [7:0] keyword_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = CH_HASH;
      3'd1: b = 8'h69;
      3'd2: b = 8'h6E;
      3'd3: b = 8'h63;
      3'd4: b = 8'h6C;
      3'd5: b = 8'h75;
      3'd6: b = 8'h64;
      3'd7: b = 8'h65;
      default: b = CH_HASH;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/include_directive_line_scanner_core.sv =====
// Include directive line scanner.
// The slave channel takes one word per cycle: tdata carries a text byte and
// tlast marks the final byte of the text. Lines end at a newline byte or at
// the final byte. For each finished line one word leaves on the master
// channel: tdata holds the path begin and end offsets, tuser tells whether a
// complete include directive was seen and whether offsets saturated, tlast
// marks the line that closes the text. Offsets are zero when no directive
// was found.
// The result word is registered and is valid in the cycle after the accepted
// line-ending byte. One byte is taken per cycle while s_axis_tready is high;
// the per-byte phase update is one compare-and-select step on scan registers.
// The output register frees itself in the same cycle it is taken, so the
// slave side stays ready while the master side accepts. When the receiver
// stalls with a result pending, s_axis_tready drops until it is taken.
// Reset clears the scan state, the position and the output valid; after the
// final byte the block returns to that state and a new text starts at 0.
`timescale 1ns / 1ps
`default_nettype none

module include_directive_line_scanner_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] path_begin, [31:16] path_end
  output logic [1:0]       m_axis_tuser,   // [0] include_found, [1] offset_overflow
  output logic             m_axis_tlast    // last_line
);

  localparam int OB = idls_pkg::OFFSET_BITS;
  localparam int FB = idls_pkg::FIELD_BITS;

  idls_pkg::phase_e            phase_q, phase_d;
  logic [2:0]                  kw_idx_q, kw_idx_d;
  logic [idls_pkg::POS_BITS-1:0] pos_cnt_q, pos_cnt_d;
  logic [OB-1:0]               begin_q, begin_d;
  logic [OB-1:0]               end_q, end_d;
  logic                        ovf_q, ovf_d;

  logic                        out_valid_q;
  logic [31:0]                 out_data_q;
  logic [1:0]                  out_user_q;
  logic                        out_last_q;

  logic                        accept;
  logic                        newline;
  logic                        pos_over;
  logic [OB-1:0]               pos;
  logic                        is_blank;
  logic                        emit;
  logic                        found;
  idls_pkg::phase_e            scan_phase;
  logic [2:0]                  scan_kw;
  logic [OB-1:0]               scan_begin;
  logic [OB-1:0]               scan_end;
  logic                        scan_ovf;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign newline  = (s_axis_tdata == idls_pkg::CH_NEWLINE);
  assign is_blank = (s_axis_tdata == idls_pkg::CH_SPACE) ||
                    (s_axis_tdata == idls_pkg::CH_TAB);
  // The counter stops one above the largest offset so overflow stays visible.
  assign pos_over = pos_cnt_q[OB];
  assign pos      = pos_over ? idls_pkg::OFFSET_MAX : pos_cnt_q[OB-1:0];
  assign emit     = newline || s_axis_tlast;

  always_comb begin
    scan_phase = phase_q;
    scan_kw    = kw_idx_q;
    scan_begin = begin_q;
    scan_end   = end_q;
    scan_ovf   = ovf_q || pos_over;
    if (!newline) begin
      unique case (phase_q)
        idls_pkg::PH_LEAD: begin
          if (is_blank) begin
            scan_phase = idls_pkg::PH_LEAD;
          end else if (s_axis_tdata == idls_pkg::CH_HASH) begin
            scan_phase = idls_pkg::PH_KEYWORD;
            scan_kw    = 3'd1;
          end else begin
            scan_phase = idls_pkg::PH_FAIL;
          end
        end
        idls_pkg::PH_KEYWORD: begin
          if (s_axis_tdata == idls_pkg::keyword_byte(kw_idx_q)) begin
            scan_kw = kw_idx_q + 3'd1;
            // Index wraps to zero after the last keyword byte.
            if (kw_idx_q == 3'(idls_pkg::KW_LEN - 1)) begin
              scan_phase = idls_pkg::PH_GAP;
            end
          end else begin
            scan_phase = idls_pkg::PH_FAIL;
          end
        end
        idls_pkg::PH_GAP: begin
          if (is_blank) begin
            scan_phase = idls_pkg::PH_GAP;
          end else if (s_axis_tdata == idls_pkg::CH_QUOTE) begin
            if (pos == idls_pkg::OFFSET_MAX) begin
              scan_begin = idls_pkg::OFFSET_MAX;
              scan_ovf   = 1'b1;
            end else begin
              scan_begin = pos + OB'(1);
            end
            scan_phase = idls_pkg::PH_PATH;
          end else begin
            scan_phase = idls_pkg::PH_FAIL;
          end
        end
        idls_pkg::PH_PATH: begin
          if (s_axis_tdata == idls_pkg::CH_QUOTE) begin
            scan_end   = pos;
            scan_phase = idls_pkg::PH_FOUND;
          end
        end
        idls_pkg::PH_FOUND: begin
          scan_phase = idls_pkg::PH_FOUND;
        end
        default: begin
          scan_phase = idls_pkg::PH_FAIL;
        end
      endcase
    end
  end

  assign found = (scan_phase == idls_pkg::PH_FOUND);

  always_comb begin
    phase_d   = scan_phase;
    kw_idx_d  = scan_kw;
    begin_d   = scan_begin;
    end_d     = scan_end;
    ovf_d     = scan_ovf;
    pos_cnt_d = pos_over ? pos_cnt_q : pos_cnt_q + idls_pkg::POS_BITS'(1);
    if (emit) begin
      phase_d  = idls_pkg::PH_LEAD;
      kw_idx_d = 3'd0;
      begin_d  = '0;
      end_d    = '0;
      if (s_axis_tlast) begin
        pos_cnt_d = '0;
        ovf_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= idls_pkg::PH_LEAD;
      kw_idx_q  <= 3'd0;
      pos_cnt_q <= '0;
      begin_q   <= '0;
      end_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      kw_idx_q  <= kw_idx_d;
      pos_cnt_q <= pos_cnt_d;
      begin_q   <= begin_d;
      end_q     <= end_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_data_q <= found ? {FB'(scan_end), FB'(scan_begin)} : 32'd0;
      out_user_q <= {scan_ovf, found};
      out_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== sv/idls_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "include_directive_line_scanner_core_macros.svh"

module idls_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic line_end_taken;

  assign line_end_taken = s_axis_tvalid && s_axis_tready &&
                          (s_axis_tlast || (s_axis_tdata == idls_pkg::CH_NEWLINE));

  `IDLS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "result word changed while stalled")
  `IDLS_ASSERT_IMPLY(a_ready_rule, clk_i, rst_ni, 1'b1,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output")
  `IDLS_ASSERT_NEXT(a_line_result, clk_i, rst_ni, line_end_taken, m_axis_tvalid,
    "line end taken without a result word")
  `IDLS_ASSERT_IMPLY(a_path_order, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[31:16] >= m_axis_tdata[15:0], "path end before path begin")
  `IDLS_ASSERT_IMPLY(a_zero_miss, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata == 32'd0, "offsets not zero without a directive")

endmodule

bind include_directive_line_scanner_core idls_checker u_idls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/include_directive_line_scanner_core_checker.sv =====
`timescale 1ns / 1ps

module include_directive_line_scanner_core_checker
  import idls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [15:0] path_begin, [31:16] path_end
  input  logic [1:0]  m_axis_tuser,   // [0] include_found, [1] offset_overflow
  input  logic        m_axis_tlast,   // last_line
  output int          fail_count,
  output int          pending_count,
  output int          lines_checked,
  output int          directives_seen
);

  typedef struct packed {
    logic        found;
    logic [15:0] path_begin;
    logic [15:0] path_end;
    logic        last_line;
    logic        overflow;
  } line_result_t;

  // The bytes of "#include".
  localparam logic [7:0] DIRECTIVE_WORD [0:7] = '{
    CH_HASH, 8'h69, 8'h6E, 8'h63, 8'h6C, 8'h75, 8'h64, 8'h65
  };

  phase_e       scan_phase;
  logic [3:0]   word_index;
  logic [16:0]  text_pos;
  logic [15:0]  quote_begin;
  logic [15:0]  quote_end;
  logic         sat_seen;
  line_result_t expected_lines[$];

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_phase      = PH_LEAD;
      word_index      = '0;
      text_pos        = '0;
      quote_begin     = '0;
      quote_end       = '0;
      sat_seen        = 1'b0;
      expected_lines.delete();
      fail_count      = 0;
      pending_count   = 0;
      lines_checked   = 0;
      directives_seen = 0;
    end else begin : step
      line_result_t got;
      line_result_t want;
      logic [15:0]  pos;
      logic [7:0]   b;

      // Compare the outgoing line result first; it can only belong to an
      // earlier byte than the one taken at this same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got.found      = m_axis_tuser[0];
        got.path_begin = m_axis_tdata[15:0];
        got.path_end   = m_axis_tdata[31:16];
        got.last_line  = m_axis_tlast;
        got.overflow   = m_axis_tuser[1];
        if (got.found) directives_seen++;
        if (expected_lines.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected line result found=%0b begin=%0d end=%0d last=%0b ovf=%0b",
                     $realtime, got.found, got.path_begin, got.path_end, got.last_line,
                     got.overflow);
        end else begin
          want = expected_lines.pop_front();
          lines_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: line %0d mismatch: expected found=%0b begin=%0d end=%0d ",
                     $realtime, lines_checked, want.found, want.path_begin, want.path_end);
              $display("last=%0b ovf=%0b, got found=%0b begin=%0d end=%0d last=%0b ovf=%0b",
                       want.last_line, want.overflow, got.found, got.path_begin,
                       got.path_end, got.last_line, got.overflow);
            end
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        b = s_axis_tdata;
        // The position counter stops one above the largest offset so that
        // saturation can be told apart from the last valid offset.
        if (text_pos > {1'b0, OFFSET_MAX}) begin
          pos      = OFFSET_MAX;
          sat_seen = 1'b1;
        end else begin
          pos      = text_pos[15:0];
          text_pos = text_pos + 17'd1;
        end

        if (b != CH_NEWLINE) begin
          case (scan_phase)
            PH_LEAD: begin
              if (b == CH_HASH) begin
                scan_phase = PH_KEYWORD;
                word_index = 4'd1;
              end else if (b != CH_SPACE && b != CH_TAB) begin
                scan_phase = PH_FAIL;
              end
            end
            PH_KEYWORD: begin
              if (word_index < 4'd8 && b == DIRECTIVE_WORD[word_index[2:0]]) begin
                word_index = word_index + 4'd1;
                if (word_index == 4'd8) scan_phase = PH_GAP;
              end else begin
                scan_phase = PH_FAIL;
              end
            end
            PH_GAP: begin
              if (b == CH_QUOTE) begin
                if (pos == OFFSET_MAX) begin
                  quote_begin = OFFSET_MAX;
                  sat_seen    = 1'b1;
                end else begin
                  quote_begin = pos + 16'd1;
                end
                scan_phase = PH_PATH;
              end else if (b != CH_SPACE && b != CH_TAB) begin
                scan_phase = PH_FAIL;
              end
            end
            PH_PATH: begin
              if (b == CH_QUOTE) begin
                quote_end  = pos;
                scan_phase = PH_FOUND;
              end
            end
            PH_FOUND: ;
            default: scan_phase = PH_FAIL;
          endcase
        end

        if (b == CH_NEWLINE || s_axis_tlast) begin
          want.found      = (scan_phase == PH_FOUND);
          want.path_begin = want.found ? quote_begin : 16'd0;
          want.path_end   = want.found ? quote_end : 16'd0;
          want.last_line  = s_axis_tlast;
          want.overflow   = sat_seen;
          expected_lines.push_back(want);
          scan_phase  = PH_LEAD;
          word_index  = '0;
          quote_begin = '0;
          quote_end   = '0;
          if (s_axis_tlast) begin
            text_pos = '0;
            sat_seen = 1'b0;
          end
        end
      end
      pending_count = expected_lines.size();
    end
  end

endmodule

// ===== verif/include_directive_line_scanner_core_tb.sv =====
`timescale 1ns / 1ps

module include_directive_line_scanner_core_tb;
  import idls_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic        s_fire = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          bytes_sent = 0;
  int          texts_sent = 0;
  int          fail_count;
  int          pending_count;
  int          lines_checked;
  int          directives_seen;

  // Each entry is {end_of_text, text_byte}.
  logic [8:0]  text_q[$];

  include_directive_line_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  include_directive_line_scanner_core_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .lines_checked   (lines_checked),
    .directives_seen (directives_seen)
  );

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #24_000_000;
    $display("Verification failed");
    $finish;
  end

  // Sampled at the rising edge, read at the falling edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_fire <= 1'b0;
    end else begin
      s_fire <= s_axis_tvalid && s_axis_tready;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic [7:0] rand_byte(input bit no_quote);
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_NEWLINE || (no_quote && b == CH_QUOTE));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    text_q.push_back({1'b0, b});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Sends the queued text, marking its final byte as the end of the text.
  task automatic send_text();
    text_q[text_q.size() - 1][8] = 1'b1;
    foreach (text_q[i]) begin
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= text_q[i][7:0];
      s_axis_tlast  <= text_q[i][8];
      @(negedge clk_i);
      while (!s_fire) @(negedge clk_i);
      bytes_sent++;
    end
    text_q.delete();
    texts_sent++;
  endtask

  task automatic wait_lines_done();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed directives with random blanks, paths and tails;
  // the rest are cut short, corrupted, noise or empty lines.
  task automatic add_random_line(input bit closes_text);
    int kind;
    int start;
    int n;
    start = text_q.size();
    kind  = $urandom_range(0, 9);
    if (kind <= 7) begin
      repeat ($urandom_range(0, 3)) push_byte(blank_byte());
      push_str("#include");
      repeat ($urandom_range(0, 3)) push_byte(blank_byte());
      push_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) push_byte(rand_byte(1'b1));
      push_byte(CH_QUOTE);
      repeat ($urandom_range(0, 4)) push_byte(rand_byte(1'b0));
      if (kind >= 6) begin
        n = $urandom_range(start, text_q.size() - 1);
        if (kind == 6) begin
          while (text_q.size() > n) void'(text_q.pop_back());
        end else begin
          text_q[n] = {1'b0, rand_byte(1'b0)};
        end
      end
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 12)) push_byte(rand_byte(1'b0));
    end
    if (!closes_text || text_q.size() == start || $urandom_range(0, 1))
      push_byte(CH_NEWLINE);
  endtask

  task automatic send_random_text();
    int lines;
    lines = $urandom_range(1, 5);
    for (int i = 0; i < lines; i++) add_random_line(i == lines - 1);
    send_text();
  endtask

  initial begin
    int phase_start;
    int fill_len;
    int guard;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 32;
    rx_idle_pct = 80;

    // Directed: minimal and padded directives, empty and unclosed paths, a
    // broken keyword, an empty line, extreme bytes, a text that ends on a
    // closing quote, one that ends on a newline and one of a single byte.
    push_str("#include\"a\"\n");
    push_str(" \t#include \t\"dir/x.h\" tail\n");
    push_str("#include \"\"\n");
    push_str("#include \"open\n");
    push_str("#inc\"\n");
    push_str("\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_NEWLINE);
    push_str("#include \"q\"");
    send_text();
    push_str("#include \"z\"\n");
    send_text();
    push_byte(8'hFF);
    send_text();
    wait_lines_done();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 32 : (p == 1) ? 80 : 0;
      rx_idle_pct = (p == 0) ? 80 : (p == 1) ? 32 : 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 320) send_random_text();
      if (p == 2) begin
        // One text long enough to run the offsets into saturation.
        fill_len = 65523 + $urandom_range(0, 8);
        push_byte(8'h78);
        repeat (fill_len - 1) push_byte(rand_byte(1'b0));
        push_byte(CH_NEWLINE);
        push_str("#include \"ab\"\n");
        push_str("#include \"c\"");
        send_text();
      end
      wait_lines_done();
    end

    guard = 0;
    while (pending_count != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);

    $display("Scanned %0d text bytes in %0d texts, one of them long enough to saturate offsets.",
             bytes_sent, texts_sent);
    $display("Compared %0d line results, %0d of them reporting an include path.",
             lines_checked, directives_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/idls_pkg.sv
sv/include_directive_line_scanner_core.sv
sv/idls_checker.sv
verif/include_directive_line_scanner_core_checker.sv
verif/include_directive_line_scanner_core_tb.sv
